// File: rtl/dsc_pkg.sv
// Shared types, round constants and SHA-256 helper functions for the
// double SHA-256 nonce checker. Used by every module in rtl/.
`default_nettype none
package dsc_pkg;

	typedef logic [31:0] word_t;

	// Request kinds carried in s_tuser.
	typedef enum logic [1:0] {
		REQ_LOAD_PREFIX = 2'd0,
		REQ_LOAD_TARGET = 2'd1,
		REQ_TEST        = 2'd2,
		REQ_UNUSED      = 2'd3
	} req_t;

	localparam int PrefixWords = 19;
	localparam int TargetWords = 8;
	localparam int Rounds      = 64;

	localparam word_t PadWord     = 32'h8000_0000;
	localparam word_t LenHeader   = 32'd640;
	localparam word_t LenDigest   = 32'd256;

	// Side data that travels with a test request down the whole pipeline.
	typedef struct packed {
		word_t                       nonce;
		logic [2:0][31:0]            tail;
		logic [TargetWords-1:0][31:0] target;
	} side_t;

	// Contents of one pipeline slot between round cells.
	typedef struct packed {
		logic             valid;
		logic [7:0][31:0] st;
		logic [15:0][31:0] win;
		logic [7:0][31:0] chain;
		side_t            side;
	} slot_t;

	// Result of one compression: chaining value plus side data.
	typedef struct packed {
		logic             valid;
		logic [7:0][31:0] hash;
		side_t            side;
	} digest_t;

	localparam logic [Rounds-1:0][31:0] KRound = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
	};

	localparam logic [7:0][31:0] HInit = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic word_t bswap(input word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage
`default_nettype wire

// File: rtl/double_sha256_nonce_check_top.sv
// Top level of the double SHA-256 nonce checker: load stores, three
// compression chains and the target compare. Depends on dsc_pkg, dsc_compress.
`default_nettype none
// The block takes one request per clock while s_tready is high. Load
// requests write a header prefix word or a target word and give no result.
// A test request gives one result after it passes through three compression
// chains of 65 register stages each (64 round cells plus a chaining add) and
// the output register. A new test may enter every cycle; the whole pipeline
// advances whenever the output register is empty or being taken, so a stalled
// output holds every stage. Prefix and target words are sampled when a test
// enters, so loads that follow it do not affect it.
module double_sha256_nonce_check_top
	import dsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // word_index[4:0], word_value[36:5], nonce[68:37], zero pad
	input  wire logic [1:0]  s_tuser,  // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // nonce_echo[31:0], hit[32], zero pad
);

	logic [4:0] word_index;
	word_t      word_value;
	word_t      nonce;
	req_t       req_type;
	logic       adv;
	logic       accept;

	logic [PrefixWords-1:0][31:0] prefix_q;
	logic [TargetWords-1:0][31:0] target_q;

	slot_t   blk1;
	slot_t   blk2;
	slot_t   blk3;
	digest_t dig1;
	digest_t dig2;
	digest_t dig3;

	logic   out_valid_q;
	word_t  out_nonce_q;
	logic   out_hit_q;
	logic   hit;

	// Request fields.
	assign word_index = s_tdata[4:0];
	assign word_value = s_tdata[36:5];
	assign nonce      = s_tdata[68:37];
	assign req_type   = req_t'(s_tuser);

	// The pipeline moves whenever the output slot can take a result.
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	// Prefix and target stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			target_q <= '0;
		end else if (accept) begin
			case (req_type)
				REQ_LOAD_PREFIX: begin
					if (word_index < 5'(PrefixWords)) begin
						prefix_q[word_index] <= word_value;
					end
				end
				REQ_LOAD_TARGET: begin
					if (word_index < 5'(TargetWords)) begin
						target_q[word_index[2:0]] <= word_value;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// First block: the first 64 header bytes.
	always_comb begin
		blk1.valid       = accept && (req_type == REQ_TEST);
		blk1.st          = HInit;
		blk1.chain       = HInit;
		for (int i = 0; i < 16; i++) begin
			blk1.win[i] = prefix_q[i];
		end
		blk1.side.nonce  = nonce;
		blk1.side.tail   = prefix_q[18:16];
		blk1.side.target = target_q;
	end

	dsc_compress u_comp1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (blk1),
		.dout   (dig1)
	);

	// Second block: header tail, nonce and padding.
	always_comb begin
		blk2.valid   = dig1.valid;
		blk2.st      = dig1.hash;
		blk2.chain   = dig1.hash;
		blk2.win     = '0;
		blk2.win[0]  = dig1.side.tail[0];
		blk2.win[1]  = dig1.side.tail[1];
		blk2.win[2]  = dig1.side.tail[2];
		blk2.win[3]  = bswap(dig1.side.nonce);
		blk2.win[4]  = PadWord;
		blk2.win[15] = LenHeader;
		blk2.side    = dig1.side;
	end

	dsc_compress u_comp2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (blk2),
		.dout   (dig2)
	);

	// Third block: first digest and padding.
	always_comb begin
		blk3.valid   = dig2.valid;
		blk3.st      = HInit;
		blk3.chain   = HInit;
		blk3.win     = '0;
		for (int i = 0; i < 8; i++) begin
			blk3.win[i] = dig2.hash[i];
		end
		blk3.win[8]  = PadWord;
		blk3.win[15] = LenDigest;
		blk3.side    = dig2.side;
	end

	dsc_compress u_comp3 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (blk3),
		.dout   (dig3)
	);

	// Byte-reversed digest against target, both as big-endian numbers.
	always_comb begin
		logic [255:0] dval;
		logic [255:0] tval;
		for (int j = 0; j < 8; j++) begin
			dval[255-32*j -: 32] = bswap(dig3.hash[7-j]);
			tval[255-32*j -: 32] = dig3.side.target[j];
		end
		hit = (dval <= tval);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dig3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_nonce_q <= dig3.side.nonce;
			out_hit_q   <= hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_hit_q, out_nonce_q};

	// A finished test in the last chain reaches the output on an advance.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dig3.valid) |=> m_tvalid)
		else $error("finished test did not reach the output register");

	// A stall holds the last chain's result in place.
	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(dig3.valid) && $stable(dig3.side.nonce))
		else $error("compression chain moved during a stall");

	// An advance with no finished test in the last chain leaves the output empty.
	a_no_shortcut: assert property (@(posedge clk) disable iff (!arst_n)
		(!dig3.valid && adv) |=> !m_tvalid)
		else $error("result appeared without a finished test");

endmodule
`default_nettype wire

// File: rtl/dsc_round_cell.sv
// One SHA-256 round cell: a round of the compression plus one step of the
// message schedule, registered. Depends on dsc_pkg.
`default_nettype none
module dsc_round_cell
	import dsc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire word_t k,
	input  wire slot_t din,
	output slot_t      dout
);

	slot_t nxt;
	logic  valid_q;
	slot_t data_q;

	// Round and schedule step.
	always_comb begin
		word_t t1;
		word_t t2;
		word_t ch;
		word_t mj;
		word_t w_new;
		t1 = '0;
		t2 = '0;
		ch = (din.st[4] & din.st[5]) ^ (~din.st[4] & din.st[6]);
		mj = (din.st[0] & din.st[1]) ^ (din.st[0] & din.st[2]) ^ (din.st[1] & din.st[2]);
		t1 = din.st[7] + bsig1(din.st[4]) + ch + k + din.win[0];
		t2 = bsig0(din.st[0]) + mj;
		w_new = din.win[0] + ssig0(din.win[1]) + din.win[9] + ssig1(din.win[14]);
		nxt = din;
		nxt.st[0] = t1 + t2;
		nxt.st[1] = din.st[0];
		nxt.st[2] = din.st[1];
		nxt.st[3] = din.st[2];
		nxt.st[4] = din.st[3] + t1;
		nxt.st[5] = din.st[4];
		nxt.st[6] = din.st[5];
		nxt.st[7] = din.st[6];
		for (int i = 0; i < 15; i++) begin
			nxt.win[i] = din.win[i+1];
		end
		nxt.win[15] = w_new;
	end

	// Valid bit is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	// Payload carries no reset.
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		dout = data_q;
		dout.valid = valid_q;
	end

endmodule
`default_nettype wire

// File: rtl/dsc_compress.sv
// One SHA-256 compression as a chain of 64 round cells and a final
// chaining add stage. Depends on dsc_pkg and dsc_round_cell.
`default_nettype none
module dsc_compress
	import dsc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire slot_t din,
	output digest_t    dout
);

	slot_t stg [0:Rounds];
	logic  valid_q;
	digest_t data_q;

	assign stg[0] = din;

	// Row of round cells, each handing its slot to the next.
	for (genvar r = 0; r < Rounds; r++) begin : g_cell
		dsc_round_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.k      (KRound[r]),
			.din    (stg[r]),
			.dout   (stg[r+1])
		);
	end

	// Add the working state back into the chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= stg[Rounds].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				data_q.hash[i] <= stg[Rounds].chain[i] + stg[Rounds].st[i];
			end
			data_q.side  <= stg[Rounds].side;
			data_q.valid <= 1'b0;
		end
	end

	always_comb begin
		dout = data_q;
		dout.valid = valid_q;
	end

endmodule
`default_nettype wire
